// ===== sv/stvn_pkg.sv =====
`timescale 1ns / 1ps
// Package for the service-type name validator: character codes, label
// indexes and the result record. No dependencies.
package stvn_pkg;

  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_HYPHEN     = 8'h2D;
  localparam logic [7:0] CH_DOT        = 8'h2E;
  localparam logic [7:0] CH_T          = 8'h74;
  localparam logic [7:0] CH_C          = 8'h63;
  localparam logic [7:0] CH_P          = 8'h70;
  localparam logic [7:0] CH_U          = 8'h75;
  localparam logic [7:0] CH_D          = 8'h64;

  localparam logic [5:0] APP_LEN_RESET = 6'd15;
  localparam logic [5:0] APP_CNT_MAX   = 6'd63;
  localparam logic [7:0] POS_MAX       = 8'd255;
  localparam logic [7:0] PROTO_LEN     = 8'd4;

  localparam int unsigned OUT_DATA_W = 24;

  typedef enum logic [1:0] {
    LBL_APP    = 2'd0,
    LBL_PROTO  = 2'd1,
    LBL_DOMAIN = 2'd2
  } label_t;

  typedef struct packed {
    logic [7:0] domain_length;
    logic       domain_given;
    logic [5:0] app_length;
    logic       protocol;
    logic       valid_res;
  } result_t;

  function automatic logic is_alnum(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h7A) ||
           (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
  endfunction

endpackage

// ===== sv/stvn_parser.sv =====
`timescale 1ns / 1ps
// Per-byte name parser: running label and match state, the length limit
// register, and the result of the name on its last byte. Uses stvn_pkg.
module stvn_parser
  import stvn_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [5:0] cfg_wdata,
  input  logic       step,       // one item is consumed this cycle
  input  logic [7:0] text_byte,
  input  logic       last,
  output result_t    res
);

  logic [5:0] max_len_r;
  logic       err_r, err_nxt;
  label_t     lbl_r, lbl_nxt;
  logic [7:0] pos_r, pos_nxt;
  logic       hyph_r, hyph_nxt;
  logic       tcp_r, tcp_nxt;
  logic       udp_r, udp_nxt;
  logic [5:0] app_r, app_nxt;
  logic [7:0] dom_r, dom_nxt;

  // State after this byte, before the end-of-name clear.
  logic       err_t, hyph_t, tcp_t, udp_t, proto_ok, ok, has_dom;
  label_t     lbl_t;
  logic [7:0] pos_t, dom_t, lc;
  logic [5:0] app_t;

  assign lc = to_lower(text_byte);

  always_comb begin
    err_t  = err_r;
    lbl_t  = lbl_r;
    pos_t  = pos_r;
    hyph_t = hyph_r;
    tcp_t  = tcp_r;
    udp_t  = udp_r;
    app_t  = app_r;
    dom_t  = dom_r;
    // A dot on the last byte is a dropped trailing dot.
    if (!(last && text_byte == CH_DOT)) begin
      if (text_byte == CH_DOT) begin
        unique case (lbl_r)
          LBL_APP: begin
            if (pos_r < 8'd2 || hyph_r) err_t = 1'b1;
            lbl_t = LBL_PROTO;
          end
          LBL_PROTO: begin
            if (!(pos_r == PROTO_LEN && (tcp_r || udp_r))) err_t = 1'b1;
            lbl_t = LBL_DOMAIN;
          end
          default: err_t = 1'b1;
        endcase
        pos_t = '0;
      end else begin
        unique case (lbl_r)
          LBL_APP: begin
            if (pos_r == 8'd0) begin
              if (text_byte != CH_UNDERSCORE) err_t = 1'b1;
            end else begin
              if (app_r >= max_len_r) err_t = 1'b1;
              if (app_r != APP_CNT_MAX) app_t = app_r + 6'd1;
              if (is_alnum(text_byte)) begin
                hyph_t = 1'b0;
              end else if (text_byte == CH_HYPHEN) begin
                if (pos_r == 8'd1 || hyph_r) err_t = 1'b1;
                hyph_t = 1'b1;
              end else begin
                err_t = 1'b1;
              end
            end
          end
          LBL_PROTO: begin
            case (pos_r)
              8'd0: begin
                if (text_byte != CH_UNDERSCORE) begin
                  tcp_t = 1'b0;
                  udp_t = 1'b0;
                end
              end
              8'd1: begin
                if (lc != CH_T) tcp_t = 1'b0;
                if (lc != CH_U) udp_t = 1'b0;
              end
              8'd2: begin
                if (lc != CH_C) tcp_t = 1'b0;
                if (lc != CH_D) udp_t = 1'b0;
              end
              8'd3: begin
                if (lc != CH_P) begin
                  tcp_t = 1'b0;
                  udp_t = 1'b0;
                end
              end
              default: ;
            endcase
          end
          default: begin
            if (dom_r != POS_MAX) dom_t = dom_r + 8'd1;
          end
        endcase
        if (pos_r != POS_MAX) pos_t = pos_r + 8'd1;
      end
    end
  end

  assign proto_ok = (pos_t == PROTO_LEN) && (tcp_t || udp_t);
  assign ok       = !err_t && (lbl_t != LBL_APP) && !(lbl_t == LBL_PROTO && !proto_ok);
  assign has_dom  = (lbl_t == LBL_DOMAIN) && (dom_t != 8'd0);

  always_comb begin
    res.valid_res     = ok;
    res.protocol      = ok & udp_t;
    res.app_length    = ok ? app_t : 6'd0;
    res.domain_given  = ok & has_dom;
    res.domain_length = (ok && has_dom) ? dom_t : 8'd0;
  end

  // The state clears after the name's last byte.
  always_comb begin
    if (last) begin
      err_nxt  = 1'b0;
      lbl_nxt  = LBL_APP;
      pos_nxt  = '0;
      hyph_nxt = 1'b0;
      tcp_nxt  = 1'b1;
      udp_nxt  = 1'b1;
      app_nxt  = '0;
      dom_nxt  = '0;
    end else begin
      err_nxt  = err_t;
      lbl_nxt  = lbl_t;
      pos_nxt  = pos_t;
      hyph_nxt = hyph_t;
      tcp_nxt  = tcp_t;
      udp_nxt  = udp_t;
      app_nxt  = app_t;
      dom_nxt  = dom_t;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= APP_LEN_RESET;
      err_r     <= 1'b0;
      lbl_r     <= LBL_APP;
      pos_r     <= '0;
      hyph_r    <= 1'b0;
      tcp_r     <= 1'b1;
      udp_r     <= 1'b1;
      app_r     <= '0;
      dom_r     <= '0;
    end else begin
      if (cfg_we) max_len_r <= cfg_wdata;
      if (step) begin
        err_r  <= err_nxt;
        lbl_r  <= lbl_nxt;
        pos_r  <= pos_nxt;
        hyph_r <= hyph_nxt;
        tcp_r  <= tcp_nxt;
        udp_r  <= udp_nxt;
        app_r  <= app_nxt;
        dom_r  <= dom_nxt;
      end
    end
  end

  // A dot inside the app label, unless it is the name's last byte, moves on to the protocol label.
  a_app_dot: assert property (@(posedge clk) disable iff (!rst_n)
    step && lbl_r == LBL_APP && text_byte == CH_DOT && !last |-> lbl_nxt == LBL_PROTO)
    else $error("dot in the app label did not move to the protocol label");

endmodule

// ===== sv/stvn_out_stage.sv =====
`timescale 1ns / 1ps
// Result output register: holds one finished result until the receiver
// takes it. Uses stvn_pkg for the result record.
module stvn_out_stage
  import stvn_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    load,
  input  result_t res_in,
  output logic    free,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t res_out
);

  logic    vld_r, vld_nxt;
  result_t res_r;

  assign free      = !vld_r || out_ready;
  assign vld_nxt   = load || (vld_r && !out_ready);
  assign out_valid = vld_r;
  assign res_out   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= 1'b0;
    else        vld_r <= vld_nxt;
  end

  always_ff @(posedge clk) begin
    if (load) res_r <= res_in;
  end

endmodule

// ===== sv/service_type_name_validator_unit.sv =====
`timescale 1ns / 1ps
// Service-type name validator, top level. Instantiates stvn_parser and
// stvn_out_stage; uses stvn_pkg.
//
// Usage:
//   A name such as "_http._tcp.local." streams in on the in_ channel, one
//   byte per item in in_tdata, with in_tlast high on its final byte. For
//   each name one result item leaves on the out_ channel; bytes without
//   in_tlast give no result. The app length limit is written through
//   cfg_we / cfg_wdata while the block is idle; it resets to 15.
//   Throughput: one byte per cycle while the result register can take a
//   result; a last byte waits while it is full. Set by the parse step
//   between the input register and the result register. Path: a last byte
//   is captured in the input register, then its result goes to out_tvalid.
//   Reset (rst_n low, synchronous) empties both registers, clears the name
//   state and restores the limit. When the receiver stalls, the result
//   waits in the output register; the next name's bytes keep flowing up
//   to its last byte, which waits in the input register until the
//   result is taken.
module service_type_name_validator_unit
  import stvn_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [5:0]            cfg_wdata,     // max_app_label_length
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,      // [7:0] text_byte
  input  logic                  in_tlast,      // last
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata      // [0] valid_res, [1] protocol,
                                               // [7:2] app_length,
                                               // [8] domain_given,
                                               // [16:9] domain_length, rest 0
);

  logic       in_vld_r, in_vld_nxt;
  logic [7:0] in_byte_r;
  logic       in_last_r;
  logic       advance, out_free, load;
  result_t    res_c, res_q;

  assign advance    = in_vld_r && (!in_last_r || out_free);
  assign load       = advance && in_last_r;
  assign in_tready  = !in_vld_r || advance;
  assign in_vld_nxt = (in_tvalid && in_tready) || (in_vld_r && !advance);

  always_ff @(posedge clk) begin
    if (!rst_n) in_vld_r <= 1'b0;
    else        in_vld_r <= in_vld_nxt;
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  stvn_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .step      (advance),
    .text_byte (in_byte_r),
    .last      (in_last_r),
    .res       (res_c)
  );

  stvn_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .res_in    (res_c),
    .free      (out_free),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .res_out   (res_q)
  );

  assign out_tdata = {{(OUT_DATA_W - $bits(result_t)){1'b0}}, res_q};

  // An invalid name reports all other fields as zero.
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !res_q.valid_res |-> res_q[$bits(result_t)-1:1] == '0)
    else $error("invalid result carries nonzero fields");

  // A missing domain reports a zero domain length.
  a_no_domain_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !res_q.domain_given |-> res_q.domain_length == 8'd0)
    else $error("domain length set without a domain");

  // A valid name always has a non-empty app label.
  a_app_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && res_q.valid_res |-> res_q.app_length != 6'd0)
    else $error("valid result with empty app label");

  // A last byte that leaves the input register produces a result next cycle.
  a_last_loads: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> out_tvalid)
    else $error("last byte consumed without a result");

  // A waiting last byte never advances while the output register is full.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !load)
    else $error("result overwritten while stalled");

endmodule
